FILE: src/pfc_pkg.sv
// pfc_pkg: shared types and constants for the pixel format converter
// no dependencies; imported by every module of the block

package pfc_pkg;

	// pixel format codes, as written to the format registers
	typedef enum logic [1:0] {
		FMT_A1R5G5B5 = 2'd0,
		FMT_R5G6B5   = 2'd1,
		FMT_A8R8G8B8 = 2'd2,
		FMT_R8G8B8   = 2'd3
	} fmt_t;

	localparam int PIXEL_W   = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 2;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT = 1'b1;

	localparam fmt_t FMT_RESET = FMT_A8R8G8B8;

	// current source and target formats
	typedef struct packed {
		fmt_t source;
		fmt_t target;
	} cfg_t;

endpackage

FILE: src/pixel_format_converter.sv
// pixel_format_converter: top level, input register, conversion and result register
// depends on pfc_pkg, pfc_cfg_regs and pfc_convert
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while the result is not stalled, set by the single conversion stage
// s_tready falls only when both the input and result registers hold items
// and the result is stalled; an empty input register still takes an item meanwhile
// reset: arst_n asynchronous, empties both registers, formats return to A8R8G8B8

module pixel_format_converter
	import pfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	// slave side
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIXEL_W-1:0]   s_tdata,   // pixel_in [31:0]
	input  logic                 s_tlast,   // end_of_run
	// master side
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [PIXEL_W-1:0]   m_tdata,   // pixel_out [31:0]
	output logic                 m_tlast    // last_pixel
);

	cfg_t cfg;

	logic               valid_s1, valid_s2;
	logic [PIXEL_W-1:0] pixel_s1, pixel_s2;
	logic               last_s1, last_s2;
	logic [PIXEL_W-1:0] converted;
	logic               adv_s1, adv_s2;

	pfc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register moves when empty or taken downstream
	assign adv_s2 = !valid_s2 || m_tready;
	// input register moves when empty or its item goes on to the result register
	assign adv_s1 = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			pixel_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	// conversion between the two registers
	pfc_convert u_convert (
		.cfg       (cfg),
		.pixel_in  (pixel_s1),
		.pixel_out (converted)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_s2 <= converted;
			last_s2  <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = pixel_s2;
	assign m_tlast  = last_s2;

`ifndef NO_ASSERTIONS
	// an item in the input register reaches the result register when it moves
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("item lost between input and result registers");

	// back-pressure only when both registers are full and the result stalls
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("s_tready low with room in the pipeline");

	// taking the last item out of an otherwise empty pipeline leaves it empty
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !valid_s1 |=> !m_tvalid)
		else $error("result repeated after being taken");
`endif

endmodule

FILE: src/pfc_cfg_regs.sv
// pfc_cfg_regs: source and target format registers behind the write port
// depends on pfc_pkg

module pfc_cfg_regs
	import pfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source <= FMT_RESET;
			cfg_q.target <= FMT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT: cfg_q.source <= fmt_t'(cfg_data);
				REG_TARGET_FORMAT: cfg_q.target <= fmt_t'(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/pfc_convert.sv
// pfc_convert: combinational rewrite of one pixel between two formats
// depends on pfc_pkg

module pfc_convert
	import pfc_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [PIXEL_W-1:0] pixel_in,
	output logic [PIXEL_W-1:0] pixel_out
);

	logic       wide;
	logic [7:0] a, r, g, b;

	// widening to A8R8G8B8 replicates the top bits into the low bits
	assign wide = (cfg.target == FMT_A8R8G8B8);

	always_comb begin
		unique case (cfg.source)
			FMT_A1R5G5B5: begin
				a = pixel_in[15] ? 8'hff : 8'h00;
				r = {pixel_in[14:10], wide ? pixel_in[14:12] : 3'b000};
				g = {pixel_in[9:5],   wide ? pixel_in[9:7]   : 3'b000};
				b = {pixel_in[4:0],   wide ? pixel_in[4:2]   : 3'b000};
			end
			FMT_R5G6B5: begin
				a = 8'hff;
				r = {pixel_in[15:11], wide ? pixel_in[15:13] : 3'b000};
				g = {pixel_in[10:5],  wide ? pixel_in[10:9]  : 2'b00};
				b = {pixel_in[4:0],   wide ? pixel_in[4:2]   : 3'b000};
			end
			FMT_A8R8G8B8: begin
				a = pixel_in[31:24];
				r = pixel_in[23:16];
				g = pixel_in[15:8];
				b = pixel_in[7:0];
			end
			default: begin
				a = 8'hff;
				r = pixel_in[23:16];
				g = pixel_in[15:8];
				b = pixel_in[7:0];
			end
		endcase
	end

	always_comb begin
		if (cfg.source == cfg.target) begin
			// same format: masked copy
			unique case (cfg.source)
				FMT_A8R8G8B8: pixel_out = pixel_in;
				FMT_R8G8B8:   pixel_out = {8'h00, pixel_in[23:0]};
				default:      pixel_out = {16'h0000, pixel_in[15:0]};
			endcase
		end else if (cfg.source == FMT_A1R5G5B5 && cfg.target == FMT_R5G6B5) begin
			// green gains a zero low bit, alpha dropped
			pixel_out = {16'h0000, pixel_in[14:5], 1'b0, pixel_in[4:0]};
		end else if (cfg.source == FMT_R5G6B5 && cfg.target == FMT_A1R5G5B5) begin
			// green loses its low bit, alpha set
			pixel_out = {16'h0000, 1'b1, pixel_in[15:6], pixel_in[4:0]};
		end else begin
			unique case (cfg.target)
				FMT_A1R5G5B5: pixel_out = {16'h0000, a[7], r[7:3], g[7:3], b[7:3]};
				FMT_R5G6B5:   pixel_out = {16'h0000, r[7:3], g[7:2], b[7:3]};
				FMT_A8R8G8B8: pixel_out = {a, r, g, b};
				default:      pixel_out = {8'h00, r, g, b};
			endcase
		end
	end

endmodule
